[rtl/core/sfc_pkg.sv]
`timescale 1ns / 1ps
// sfc_pkg: shared types and constants for the SLIP framer with CRC-16/ARC.
// No dependencies; used by every file in rtl/core.
package sfc_pkg;

	localparam int CONTENT_BYTES = 1024;
	localparam int HDR_BYTES     = 7;
	localparam int ADDR_W        = (CONTENT_BYTES > 1) ? $clog2(CONTENT_BYTES) : 1;
	localparam int CNT_W         = $clog2(CONTENT_BYTES + 1);
	localparam int POS_W         = $clog2(CONTENT_BYTES + HDR_BYTES + 1);

	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [7:0]  SLIP_ESC     = 8'hDB;
	localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
	localparam logic [7:0]  SLIP_END     = 8'hC0;
	localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
	localparam logic [7:0]  FRAME_VER    = 8'h01;
	localparam logic [7:0]  FRAME_SEQ    = 8'h01;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_PULL   = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic [7:0] channel;
		logic       want_ack;
	} cmd_t;

	typedef struct packed {
		logic       valid_res;
		logic [7:0] out_byte;
		logic       frame_end;
	} res_t;

	// control into the serial CRC unit
	typedef struct packed {
		logic load;   // fold a byte in and start eight shift steps
		logic clear;  // back to the initial value
	} crc_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CRC  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

[rtl/core/sfc_crc16_serial.sv]
`timescale 1ns / 1ps
// sfc_crc16_serial: bit-serial reflected CRC-16 (poly 0xA001), one bit a cycle.
// Depends on sfc_pkg.
module sfc_crc16_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  sfc_pkg::crc_ctrl_t ctrl,
	input  logic [7:0]        data,
	output logic [15:0]       crc,
	output logic              last
);
	import sfc_pkg::*;

	logic [15:0] crc_q;
	logic [2:0]  bit_q;
	logic        active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			bit_q    <= '0;
			active_q <= 1'b0;
		end else if (ctrl.clear) begin
			crc_q    <= '0;
			bit_q    <= '0;
			active_q <= 1'b0;
		end else if (ctrl.load) begin
			crc_q    <= crc_q ^ {8'h00, data};
			bit_q    <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			crc_q    <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			bit_q    <= bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				active_q <= 1'b0;
			end
		end
	end

	assign crc  = crc_q;
	assign last = active_q && (bit_q == 3'd7);

endmodule

[rtl/core/slip_packet_framer_crc16.sv]
`timescale 1ns / 1ps
// slip_packet_framer_crc16: top level of the SLIP framer with CRC-16/ARC.
// Depends on sfc_pkg and sfc_crc16_serial.
//
//  channel  ports               handshake
//  -------  ------------------  ---------------------------------------------
//  command  start, busy, cmd    item taken at clk edge with start && !busy
//  result   done, res           res valid for the single cycle done is high
//
// Items: a stored append is accepted and then keeps busy for the 8 CRC shift
// steps in the serial CRC unit; a dropped or ignored append, a finish and mode 3
// leave the block idle; a pull enters EMIT (content store read is registered,
// then the frame byte and SLIP escape are formed and registered). A pull's
// result is strobed by done_q, registered in EMIT once the state register enters it.
// Reset (arst_n low) clears count, CRC and framing state at once; the
// content store has no reset and needs no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module slip_packet_framer_crc16 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sfc_pkg::cmd_t cmd,
	output logic          done,
	output sfc_pkg::res_t res
);
	import sfc_pkg::*;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_W-1:0]    pos_q;
	logic [7:0]          chan_q;
	logic                ack_q;
	logic                sending_q;
	logic                esc_pend_q;
	logic                esc_end_q;
	logic                done_q;
	res_t                res_q;

	// content store: written on append, read continuously at the frame position
	logic [7:0]          mem [CONTENT_BYTES];
	logic [7:0]          rd_q;
	logic [ADDR_W-1:0]   rd_idx;
	logic [POS_W-1:0]    pos_off;

	logic                accept;
	logic                do_append;
	crc_ctrl_t           crc_ctrl;
	logic [15:0]         crc;
	logic                crc_last;

	// frame byte selection and escape decision for the EMIT state
	logic [11:0]         len12;
	logic [7:0]          fbyte;
	logic                in_frame;
	res_t                res_d;
	logic                emit_adv;   // position steps on
	logic                emit_esc;   // escape prefix sent, second byte due
	logic                emit_close; // closing END sent

	assign accept    = start && !busy;
	assign do_append = accept && (cmd.mode == MODE_APPEND) && !sending_q
	                   && (count_q != CNT_W'(CONTENT_BYTES));

	always_ff @(posedge clk) begin
		if (do_append) begin
			mem[count_q[ADDR_W-1:0]] <= cmd.data_byte;
		end
		rd_q <= mem[rd_idx];
	end

	assign pos_off = pos_q - POS_W'(HDR_BYTES);
	assign rd_idx  = pos_off[ADDR_W-1:0];

	assign crc_ctrl.load  = do_append;
	assign crc_ctrl.clear = emit_close;

	sfc_crc16_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (cmd.data_byte),
		.crc    (crc),
		.last   (crc_last)
	);

	assign len12    = 12'(count_q);
	assign in_frame = pos_q < (POS_W'(HDR_BYTES) + POS_W'(count_q));

	always_comb begin
		case (pos_q)
			POS_W'(0): fbyte = crc[7:0];
			POS_W'(1): fbyte = crc[15:8];
			POS_W'(2): fbyte = FRAME_VER;
			POS_W'(3): fbyte = len12[7:0];
			POS_W'(4): fbyte = {ack_q, 3'b000, len12[11:8]};
			POS_W'(5): fbyte = chan_q;
			POS_W'(6): fbyte = FRAME_SEQ;
			default:   fbyte = rd_q;
		endcase
	end

	always_comb begin
		res_d      = '0;
		emit_adv   = 1'b0;
		emit_esc   = 1'b0;
		emit_close = 1'b0;
		if (state_q == ST_EMIT && sending_q) begin
			res_d.valid_res = 1'b1;
			if (esc_pend_q) begin
				res_d.out_byte = esc_end_q ? SLIP_ESC_END : SLIP_ESC_ESC;
				emit_adv       = 1'b1;
			end else if (in_frame) begin
				if (fbyte inside {SLIP_ESC, SLIP_END}) begin
					res_d.out_byte = SLIP_ESC;
					emit_esc       = 1'b1;
				end else begin
					res_d.out_byte = fbyte;
					emit_adv       = 1'b1;
				end
			end else begin
				res_d.out_byte  = SLIP_END;
				res_d.frame_end = 1'b1;
				emit_close      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			chan_q     <= '0;
			ack_q      <= 1'b0;
			sending_q  <= 1'b0;
			esc_pend_q <= 1'b0;
			esc_end_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.mode)
							MODE_APPEND: begin
								if (do_append) begin
									count_q <= count_q + CNT_W'(1);
									state_q <= ST_CRC;
								end
							end
							MODE_FINISH: begin
								if (!sending_q) begin
									chan_q     <= cmd.channel;
									ack_q      <= cmd.want_ack;
									sending_q  <= 1'b1;
									pos_q      <= '0;
									esc_pend_q <= 1'b0;
									esc_end_q  <= 1'b0;
								end
							end
							MODE_PULL: state_q <= ST_EMIT;
							default: ;
						endcase
					end
				end
				ST_CRC: begin
					if (crc_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (emit_adv) begin
						pos_q      <= pos_q + POS_W'(1);
						esc_pend_q <= 1'b0;
						esc_end_q  <= 1'b0;
					end
					if (emit_esc) begin
						esc_pend_q <= 1'b1;
						esc_end_q  <= (fbyte == SLIP_END);
					end
					if (emit_close) begin
						sending_q <= 1'b0;
						pos_q     <= '0;
						count_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			res_q <= res_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/core/sfc_checker.sv]
`timescale 1ns / 1ps
// sfc_checker: port-level assertions for slip_packet_framer_crc16, and its bind.
// Depends on sfc_pkg.
module sfc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          busy,
	input logic          done,
	input sfc_pkg::res_t res
);
	import sfc_pkg::*;

	// a pull passes through IDLE and EMIT again before its strobe, so strobes never touch
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// every result comes from a pull that kept the block busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding busy cycle");

	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.frame_end) |-> (res.valid_res && res.out_byte == SLIP_END))
		else $error("frame end is not a valid END byte");

	// escaping keeps END out of the frame body
	a_no_raw_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.valid_res && !res.frame_end) |-> (res.out_byte != SLIP_END))
		else $error("unescaped END inside frame");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.valid_res) |-> (res.out_byte == 8'h00 && !res.frame_end))
		else $error("idle pull result not zero");

endmodule

bind slip_packet_framer_crc16 sfc_checker u_sfc_checker (.*);

[tb/tb_slip_packet_framer_crc16.sv]
`timescale 1ns / 1ps
// tb_slip_packet_framer_crc16: self-checking bench for the SLIP framer with CRC-16/ARC.
// Depends on sfc_pkg and the slip_packet_framer_crc16 RTL; predicts every pulled byte
// from its own model of the framer and compares each strobed result with it.
module tb_slip_packet_framer_crc16;
	import sfc_pkg::*;

	// mode 3 has no meaning in the block; it must be swallowed without a result
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// no acceptance and no result for this many cycles means the block has hung
	localparam int STALL_LIMIT = 2000;
	// time for a last pull's byte to arrive and an append's CRC shift steps to end
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	res_t res;

	slip_packet_framer_crc16 uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---- framer model: message buffer, running CRC and transmit position ----
	logic [7:0]  msg_buf [CONTENT_BYTES];
	logic [15:0] msg_len;
	logic [15:0] msg_crc;
	logic [7:0]  hdr_channel;
	logic        hdr_ack;
	logic        tx_active;
	int          tx_pos;
	logic        esc_due;   // second byte of an escape pair still to go
	logic        esc_end;   // ... and it is DC rather than DD

	res_t frame_bytes_due[$];  // bytes owed by pulls already accepted
	int   fail_count;
	int   taken_items;         // items that changed state or produced a byte
	bit   gaps_on;
	res_t want_res;

	function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// unescaped byte at a given frame position: 7-byte header, then content
	function automatic logic [7:0] frame_octet(int pos);
		case (pos)
			0: return msg_crc[7:0];
			1: return msg_crc[15:8];
			2: return FRAME_VER;
			3: return msg_len[7:0];
			4: return {hdr_ack, 3'b000, msg_len[11:8]};
			5: return hdr_channel;
			6: return FRAME_SEQ;
			default: return msg_buf[pos - HDR_BYTES];
		endcase
	endfunction

	// advance the model by one accepted item; returns 1 if the item had any effect
	function automatic bit slip_frame_predict(cmd_t c);
		res_t r;
		logic [7:0] b;
		r = '0;
		case (c.mode)
			MODE_APPEND: begin
				if (tx_active || msg_len >= CONTENT_BYTES)
					return 1'b0;
				msg_buf[msg_len] = c.data_byte;
				msg_crc = crc16_arc_byte(msg_crc, c.data_byte);
				msg_len++;
				return 1'b1;
			end
			MODE_FINISH: begin
				if (tx_active)
					return 1'b0;
				hdr_channel = c.channel;
				hdr_ack = c.want_ack;
				tx_active = 1'b1;
				tx_pos = 0;
				esc_due = 1'b0;
				esc_end = 1'b0;
				return 1'b1;
			end
			MODE_PULL: begin
				if (tx_active) begin
					r.valid_res = 1'b1;
					if (esc_due) begin
						r.out_byte = esc_end ? SLIP_ESC_END : SLIP_ESC_ESC;
						esc_due = 1'b0;
						esc_end = 1'b0;
						tx_pos++;
					end else if (tx_pos < HDR_BYTES + msg_len) begin
						b = frame_octet(tx_pos);
						if (b == SLIP_ESC || b == SLIP_END) begin
							r.out_byte = SLIP_ESC;
							esc_due = 1'b1;
							esc_end = (b == SLIP_END);
						end else begin
							r.out_byte = b;
							tx_pos++;
						end
					end else begin
						// closing END; message state cleared for the next one
						r.out_byte = SLIP_END;
						r.frame_end = 1'b1;
						tx_active = 1'b0;
						tx_pos = 0;
						msg_len = '0;
						msg_crc = '0;
					end
				end
				frame_bytes_due.push_back(r);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// ---- result checker: every strobed byte against the oldest one owed ----
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (frame_bytes_due.size() == 0) begin
				note_failure($sformatf("unexpected result valid=%0b byte=%02h end=%0b",
					res.valid_res, res.out_byte, res.frame_end));
			end else begin
				want_res = frame_bytes_due.pop_front();
				if (res.valid_res !== want_res.valid_res)
					note_failure($sformatf("valid_res mismatch: exp %0b got %0b",
						want_res.valid_res, res.valid_res));
				if (res.out_byte !== want_res.out_byte)
					note_failure($sformatf("out_byte mismatch: exp %02h got %02h",
						want_res.out_byte, res.out_byte));
				if (res.frame_end !== want_res.frame_end)
					note_failure($sformatf("frame_end mismatch: exp %0b got %0b",
						want_res.frame_end, res.frame_end));
			end
		end
	end

	// ---- watchdog: ends the run if nothing moves for too long ----
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// ---- stimulus helpers ----
	function automatic cmd_t make_cmd(logic [1:0] m, logic [7:0] d, logic [7:0] ch, logic ack);
		cmd_t c;
		c.mode = m;
		c.data_byte = d;
		c.channel = ch;
		c.want_ack = ack;
		return c;
	endfunction

	// byte with a strong bias towards the SLIP specials so escapes come often
	function automatic logic [7:0] rand_octet();
		case ($urandom_range(0, 7))
			0: return SLIP_ESC;
			1: return SLIP_END;
			2: return $urandom_range(0, 1) ? SLIP_ESC_ESC : SLIP_ESC_END;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic cmd_t rand_noise();
		return make_cmd(2'($urandom_range(0, 3)), rand_octet(), rand_octet(),
			1'($urandom_range(0, 1)));
	endfunction

	// present one item and hold it until the block takes it; start stays high on
	// return, so the caller either sends again or paces in the same time step
	task automatic send_item(cmd_t c);
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (slip_frame_predict(c))
			taken_items++;
	endtask

	// sender gap: mostly none or short, now and then long
	task automatic pace();
		int n;
		n = 0;
		if (gaps_on) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: n = 0;
				9: n = $urandom_range(10, 40);
				default: n = $urandom_range(1, 3);
			endcase
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_paced(cmd_t c);
		send_item(c);
		pace();
	endtask

	// hold the sender back until every owed byte has been seen; start goes low
	// before the wait, so it is never set and cleared in the same time step
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (frame_bytes_due.size() != 0);
	endtask

	// pull until the model reports the frame closed, optionally with stray items
	task automatic pull_frame_out(bit noisy);
		while (tx_active) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_paced(rand_noise());
			else
				send_paced(make_cmd(MODE_PULL, rand_octet(), rand_octet(), 1'b0));
		end
	endtask

	// ---- tests ----
	// pulls with no frame give an all-zero byte; mode 3 does nothing at all
	task automatic test_idle_and_unused();
		send_paced(make_cmd(MODE_PULL, 8'h00, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1));
		send_paced(make_cmd(MODE_PULL, 8'hFF, 8'hFF, 1'b1));
	endtask

	// frame with no content: header only, ack set, channel all ones
	task automatic test_empty_frame();
		send_paced(make_cmd(MODE_FINISH, 8'h00, 8'hFF, 1'b1));
		pull_frame_out(1'b0);
	endtask

	// both specials in content and END in the header, plus append/finish while sending
	task automatic test_escape_bytes();
		send_paced(make_cmd(MODE_APPEND, SLIP_ESC, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_APPEND, SLIP_END, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_APPEND, 8'h00, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_APPEND, 8'hFF, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_APPEND, SLIP_ESC_ESC, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_APPEND, SLIP_ESC_END, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_FINISH, 8'h00, SLIP_END, 1'b0));
		send_paced(make_cmd(MODE_PULL, 8'h00, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_PULL, 8'h00, 8'h00, 1'b0));
		// sending: both of these must leave the frame untouched
		send_paced(make_cmd(MODE_APPEND, 8'h55, 8'h00, 1'b0));
		send_paced(make_cmd(MODE_FINISH, 8'h00, 8'hAA, 1'b1));
		pull_frame_out(1'b0);
	endtask

	// overfill the buffer: the excess is dropped and length reads as full
	task automatic test_buffer_full();
		drain_results();
		gaps_on = 1'b0;
		repeat (CONTENT_BYTES + 3)
			send_paced(make_cmd(MODE_APPEND, rand_octet(), 8'h00, 1'b0));
		gaps_on = 1'b1;
		send_paced(make_cmd(MODE_FINISH, 8'h00, 8'h5A, 1'b1));
		pull_frame_out(1'b1);
	endtask

	// mostly well-formed messages of random content, with stray items between
	task automatic test_random_frames();
		int target;
		int len;
		target = taken_items + 400;
		while (taken_items < target) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				drain_results();
			while ($urandom_range(0, 4) == 0)
				send_paced(rand_noise());
			case ($urandom_range(0, 19))
				0: len = $urandom_range(65, 300);
				1, 2, 3, 4, 5: len = $urandom_range(17, 64);
				default: len = $urandom_range(0, 16);
			endcase
			repeat (len) begin
				if ($urandom_range(0, 19) == 0)
					send_paced(make_cmd(MODE_UNUSED, rand_octet(), rand_octet(), 1'b1));
				else
					send_paced(make_cmd(MODE_APPEND, rand_octet(), rand_octet(),
						1'($urandom_range(0, 1))));
			end
			if (!tx_active)
				send_paced(make_cmd(MODE_FINISH, rand_octet(), rand_octet(),
					1'($urandom_range(0, 1))));
			pull_frame_out(1'b1);
		end
	endtask

	// ---- main sequence ----
	initial begin
		msg_len = '0;
		msg_crc = '0;
		hdr_channel = '0;
		hdr_ack = 1'b0;
		tx_active = 1'b0;
		tx_pos = 0;
		esc_due = 1'b0;
		esc_end = 1'b0;
		fail_count = 0;
		taken_items = 0;
		gaps_on = 1'b1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_and_unused();
		test_empty_frame();
		test_escape_bytes();
		test_buffer_full();
		test_random_frames();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (frame_bytes_due.size() != 0)
			note_failure($sformatf("%0d results never arrived", frame_bytes_due.size()));

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
